/* rtl/rftk_pkg.sv */
// Shared types and constants of the range-filtered top-k selector.
package rftk_pkg;

    // Store depth and derived widths
    localparam int MAX_K     = 16;
    localparam int CNT_W     = $clog2(MAX_K + 1);
    localparam int SCORE_W   = 32;
    localparam int ID_W      = 32;
    localparam int K_W       = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEST_K    = 2'd2;

    // Configuration reset values
    localparam logic signed [SCORE_W-1:0] SCORE_MIN_RST = -32'sd1966080;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX_RST = 32'sd0;
    localparam logic [K_W-1:0]            BEST_K_RST    = 5'd16;

    // Action codes
    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Candidate word
    typedef struct packed {
        logic                      action;
        logic                      has_score;
        logic signed [SCORE_W-1:0] score;
        logic [ID_W-1:0]           item_id;
    } rftk_cand_t;

    // Result word
    typedef struct packed {
        logic [ID_W-1:0]           item_id_res;
        logic signed [SCORE_W-1:0] score_res;
        logic                      last;
        logic                      empty_res;
    } rftk_res_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMPTY
    } rftk_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic offer;
        logic drain;
        logic empty;
    } rftk_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic slot_free;
        logic cnt_zero;
        logic cnt_one;
    } rftk_sts_t;

endpackage

/* rtl/rftk_ctrl.sv */
// Controller state machine of the top-k selector: accepts words, sequences flushes.
module rftk_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cand_valid,
    input  logic              cand_action,
    input  rftk_pkg::rftk_sts_t sts,
    output logic              cand_stall,
    output rftk_pkg::rftk_cmd_t cmd
);

    rftk_pkg::rftk_state_t state_reg;
    rftk_pkg::rftk_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rftk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rftk_pkg::ST_IDLE:
            begin
                if (cand_valid && cand_action == rftk_pkg::ACT_FLUSH)
                begin
                    state_next = sts.cnt_zero ? rftk_pkg::ST_EMPTY : rftk_pkg::ST_DRAIN;
                end
            end
            rftk_pkg::ST_DRAIN:
            begin
                // last entry leaves the store
                if (sts.slot_free && sts.cnt_one)
                begin
                    state_next = rftk_pkg::ST_IDLE;
                end
            end
            rftk_pkg::ST_EMPTY:
            begin
                if (sts.slot_free)
                begin
                    state_next = rftk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rftk_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cand_stall = 1'b1;
        cmd        = '0;
        case (state_reg)
            rftk_pkg::ST_IDLE:
            begin
                cand_stall = 1'b0;
                cmd.offer  = cand_valid && (cand_action == rftk_pkg::ACT_OFFER);
            end
            rftk_pkg::ST_DRAIN:
            begin
                cmd.drain = sts.slot_free;
            end
            rftk_pkg::ST_EMPTY:
            begin
                cmd.empty = sts.slot_free;
            end
            default:
            begin
                cand_stall = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/rftk_dp.sv */
// Datapath of the top-k selector: config registers, sorted insertion row, result register.
module rftk_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rftk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rftk_pkg::CFG_W-1:0]           cfg_data,
    input  rftk_pkg::rftk_cand_t                 cand,
    input  rftk_pkg::rftk_cmd_t                  cmd,
    input  logic                                 res_stall,
    output rftk_pkg::rftk_sts_t                  sts,
    output logic                                 res_valid,
    output rftk_pkg::rftk_res_t                  res
);

    localparam int MK = rftk_pkg::MAX_K;
    localparam int CW = rftk_pkg::CNT_W;

    // Configuration
    logic signed [rftk_pkg::SCORE_W-1:0] score_min_reg;
    logic signed [rftk_pkg::SCORE_W-1:0] score_max_reg;
    logic [rftk_pkg::K_W-1:0]            best_k_reg;

    // Sorted store, entry 0 holds the lowest score
    logic signed [rftk_pkg::SCORE_W-1:0] score_reg  [MK];
    logic signed [rftk_pkg::SCORE_W-1:0] score_next [MK];
    logic [rftk_pkg::ID_W-1:0]           id_reg     [MK];
    logic [rftk_pkg::ID_W-1:0]           id_next    [MK];
    logic [CW-1:0]                       cnt_reg;
    logic [CW-1:0]                       cnt_next;

    // Result register
    logic                res_valid_reg;
    logic                res_valid_next;
    rftk_pkg::rftk_res_t res_reg;
    rftk_pkg::rftk_res_t res_next;

    logic [MK-1:0] held;
    logic [MK-1:0] le;
    logic [CW-1:0] k_eff;
    logic          below_k;
    logic          in_range;
    logic          admit;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_min_reg <= rftk_pkg::SCORE_MIN_RST;
            score_max_reg <= rftk_pkg::SCORE_MAX_RST;
            best_k_reg    <= rftk_pkg::BEST_K_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rftk_pkg::CFG_SCORE_MIN: score_min_reg <= $signed(cfg_data);
                rftk_pkg::CFG_SCORE_MAX: score_max_reg <= $signed(cfg_data);
                rftk_pkg::CFG_BEST_K:    best_k_reg    <= cfg_data[rftk_pkg::K_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Effective limit: zero acts as one, saturates at store size
    always_comb
    begin
        if (best_k_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (int'(best_k_reg) > MK)
        begin
            k_eff = CW'(MK);
        end
        else
        begin
            k_eff = CW'(best_k_reg);
        end
    end

    // Per-entry compare: held entries whose score is at or below the candidate
    always_comb
    begin
        for (int i = 0; i < MK; i++)
        begin
            held[i] = (CW'(i) < cnt_reg);
            le[i]   = held[i] && (score_reg[i] <= cand.score);
        end
    end

    // Admission: in range, and room left or strictly below the worst entry
    assign below_k  = (cnt_reg < k_eff);
    assign in_range = !(cand.score > score_max_reg) && !(cand.score < score_min_reg);
    assign admit    = cand.has_score && in_range && (below_k || |(held & ~le));

    // Store next state: insert-and-shift up, or shift down on drain
    always_comb
    begin
        score_next = score_reg;
        id_next    = id_reg;
        cnt_next   = cnt_reg;
        if (cmd.offer && admit)
        begin
            if (!le[0])
            begin
                score_next[0] = cand.score;
                id_next[0]    = cand.item_id;
            end
            for (int i = 1; i < MK; i++)
            begin
                if (!le[i])
                begin
                    if (le[i-1])
                    begin
                        score_next[i] = cand.score;
                        id_next[i]    = cand.item_id;
                    end
                    else
                    begin
                        score_next[i] = score_reg[i-1];
                        id_next[i]    = id_reg[i-1];
                    end
                end
            end
            // a full store drops its worst entry, count unchanged
            if (below_k)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        else if (cmd.drain)
        begin
            for (int i = 0; i < MK - 1; i++)
            begin
                score_next[i] = score_reg[i+1];
                id_next[i]    = id_reg[i+1];
            end
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // Store payload, no reset needed
    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        id_reg    <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Result register load
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (cmd.drain)
        begin
            res_next.item_id_res = id_reg[0];
            res_next.score_res   = score_reg[0];
            res_next.last        = (cnt_reg == CW'(1));
            res_next.empty_res   = 1'b0;
            res_valid_next       = 1'b1;
        end
        else if (cmd.empty)
        begin
            res_next.item_id_res = '0;
            res_next.score_res   = '0;
            res_next.last        = 1'b1;
            res_next.empty_res   = 1'b1;
            res_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Status to controller
    assign sts.slot_free = !res_valid_reg || !res_stall;
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.cnt_one   = (cnt_reg == CW'(1));

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/range_filtered_top_k_selector_core.sv */
// Top level of the range-filtered top-k selector: controller plus datapath.
//
//   channel | signals                          | carries
//   --------+----------------------------------+-------------------------------
//   cand    | cand_valid, cand_stall, cand     | offer or flush word in
//   res     | res_valid, res_stall, res        | kept entries, ascending score
//   cfg     | cfg_we, cfg_index, cfg_data      | score_min, score_max, best_k
//
// Compare and shift across all entries are combinational, so offer words
// stream one per cycle while cand_stall is low.
// A flush sends the held entries out of the result register one word per
// cycle, paced by res_stall; an empty flush sends one word with empty_res
// and last set. cand_stall is high while a flush drains.
// rst_n clears the configuration to its defaults and empties the store.
module range_filtered_top_k_selector_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cand_valid,
    output logic                           cand_stall,
    input  rftk_pkg::rftk_cand_t           cand,
    output logic                           res_valid,
    input  logic                           res_stall,
    output rftk_pkg::rftk_res_t            res,
    input  logic                           cfg_we,
    input  logic [rftk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rftk_pkg::CFG_W-1:0]     cfg_data
);

    rftk_pkg::rftk_cmd_t cmd;
    rftk_pkg::rftk_sts_t sts;

    rftk_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cand_valid  (cand_valid),
        .cand_action (cand.action),
        .sts         (sts),
        .cand_stall  (cand_stall),
        .cmd         (cmd)
    );

    rftk_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cand      (cand),
        .cmd       (cmd),
        .res_stall (res_stall),
        .sts       (sts),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule
